FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; all sample on clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/gls_pkg.sv
// Types and constants for the gate layer scheduler.
`timescale 1ns / 1ps

package gls_pkg;

	localparam int QUBIT_W   = 4;
	localparam int QCOUNT_W  = 5;
	localparam int STATUS_W  = 3;
	localparam int SLICE_W   = 10;
	localparam int FILL_W    = 5;
	localparam int DEPTH_W   = 11;
	localparam int INDEX_W   = 16;

	localparam logic [QCOUNT_W-1:0] QCOUNT_RESET = 5'd16;
	localparam logic [FILL_W-1:0]   FILL_MAX     = 5'd31;
	localparam logic [INDEX_W-1:0]  INDEX_MAX    = 16'hFFFF;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_BAD_QUBIT   = 3'd1,
		ST_BAD_CONTROL = 3'd2,
		ST_SAME_LINE   = 3'd3,
		ST_FULL        = 3'd4
	} status_t;

	typedef struct packed {
		logic [QUBIT_W-1:0] qubit;
		logic               has_control;
		logic [QUBIT_W-1:0] control;
	} gate_t;

	typedef struct packed {
		status_t            status;
		logic [SLICE_W-1:0] slice;
		logic [FILL_W-1:0]  slice_fill;
		logic [DEPTH_W-1:0] depth;
		logic [INDEX_W-1:0] gate_index;
	} result_t;

endpackage

FILE: hw/rtl/gls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/gate_layer_scheduler_top.sv
// Gate layer scheduler: as-soon-as-possible slice placement of one- and two-line gates.
//
// Channels: gate_valid/gate_stall/gate carries one gate per transfer (target line, optional
// control line). result_valid/result_stall/result returns exactly one result per gate, in
// order: status, slice, fill of that slice, circuit depth and arrival index.
// cfg_wr_en/cfg_wr_data writes the qubit line count; write it only while the block is idle.
// A transferred gate passes the two work stages and the output register before its result
// leaves. Throughput: one gate per cycle, sustained while result_stall stays low.
// Stage 1 validates the gate and picks the slice from the per-line next-free slots; those
// slots live in four small RAMs (two read ports times two write ports, a per-line select
// bit tells which write port holds the newest value) and one-deep forwarding covers the
// write that lands on the same edge as the read. Stage 2 reads and bumps the per-slice
// gate count in a slice-deep RAM, again with one-deep forwarding.
// Reset: all lines start at slot 0, depth and gate counter are 0, line count is 16. The
// slice count RAM needs no clearing pass: a slice is read as empty unless it lies below
// the current depth, and every slice below the depth has been written. The block takes
// gates from the first cycle after reset.
// Stall: a stalled result holds in the output register; the two work stages keep filling
// behind it, so gate_stall rises only once every stage holds a gate.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gate_layer_scheduler_top #(
	parameter int MAX_QUBITS = 16,
	parameter int MAX_SLICES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [gls_pkg::QCOUNT_W-1:0]  cfg_wr_data,
	input  logic                          gate_valid,
	output logic                          gate_stall,
	input  gls_pkg::gate_t                gate,
	output logic                          result_valid,
	input  logic                          result_stall,
	output gls_pkg::result_t              result
);

	localparam int LW = $clog2(MAX_QUBITS);      // line index width
	localparam int PW = $clog2(MAX_SLICES);      // slice index width
	localparam int NW = $clog2(MAX_SLICES + 1);  // next-free slot / depth width
	localparam int SLICE_W = gls_pkg::SLICE_W;
	localparam int DEPTH_W = gls_pkg::DEPTH_W;
	localparam int FILL_W  = gls_pkg::FILL_W;
	localparam int INDEX_W = gls_pkg::INDEX_W;
	localparam logic [5:0]    MAXQ        = 6'(MAX_QUBITS);
	localparam logic [NW-1:0] SLICE_LIMIT = NW'(MAX_SLICES);

	// ---------------- handshake and stage control ----------------
	logic s1_vld_q, s2_vld_q, res_vld_q;
	logic out_free, s2_adv, s1_adv, gate_acc;

	assign out_free   = !res_vld_q || !result_stall;
	assign s2_adv     = s2_vld_q && out_free;
	assign s1_adv     = s1_vld_q && (!s2_vld_q || out_free);
	assign gate_stall = s1_vld_q && !(!s2_vld_q || out_free);
	assign gate_acc   = gate_valid && !gate_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			s2_vld_q  <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (gate_acc) begin
				s1_vld_q <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_vld_q <= 1'b1;
			end else if (s2_adv) begin
				s2_vld_q <= 1'b0;
			end
			if (s2_adv) begin
				res_vld_q <= 1'b1;
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_vld_q;

	// ---------------- configuration ----------------
	logic [gls_pkg::QCOUNT_W-1:0] qcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcount_q <= gls_pkg::QCOUNT_RESET;
		end else if (cfg_wr_en) begin
			qcount_q <= cfg_wr_data;
		end
	end

	// ---------------- per-line next-free slot store ----------------
	// Port A is written at the target line, port B at the control line.
	logic [MAX_QUBITS-1:0] line_vld_q;   // line has been written since reset
	logic [MAX_QUBITS-1:0] line_sel_q;   // 1: newest value sits in the B copies
	logic [LW-1:0]         rd_t_line, rd_c_line;
	logic [NW-1:0]         rd_at, rd_ac, rd_bt, rd_bc;
	logic                  nfs_we_a, nfs_we_b;
	logic [LW-1:0]         wr_t_line, wr_c_line;
	logic [NW-1:0]         nfs_wdata;

	assign rd_t_line = LW'(gate.qubit);
	assign rd_c_line = LW'(gate.control);

	gls_ram #(.WIDTH(NW), .DEPTH(MAX_QUBITS)) u_nfs_at (
		.clk(clk), .we(nfs_we_a), .waddr(wr_t_line), .wdata(nfs_wdata),
		.re(gate_acc), .raddr(rd_t_line), .rdata(rd_at)
	);
	gls_ram #(.WIDTH(NW), .DEPTH(MAX_QUBITS)) u_nfs_ac (
		.clk(clk), .we(nfs_we_a), .waddr(wr_t_line), .wdata(nfs_wdata),
		.re(gate_acc), .raddr(rd_c_line), .rdata(rd_ac)
	);
	gls_ram #(.WIDTH(NW), .DEPTH(MAX_QUBITS)) u_nfs_bt (
		.clk(clk), .we(nfs_we_b), .waddr(wr_c_line), .wdata(nfs_wdata),
		.re(gate_acc), .raddr(rd_t_line), .rdata(rd_bt)
	);
	gls_ram #(.WIDTH(NW), .DEPTH(MAX_QUBITS)) u_nfs_bc (
		.clk(clk), .we(nfs_we_b), .waddr(wr_c_line), .wdata(nfs_wdata),
		.re(gate_acc), .raddr(rd_c_line), .rdata(rd_bc)
	);

	// ---------------- stage 1: validate and place ----------------
	gls_pkg::gate_t gate_s1;
	logic           t_vld_s1, t_sel_s1, c_vld_s1, c_sel_s1;

	always_ff @(posedge clk) begin
		if (gate_acc) begin
			gate_s1  <= gate;
			t_vld_s1 <= line_vld_q[rd_t_line];
			t_sel_s1 <= line_sel_q[rd_t_line];
			c_vld_s1 <= line_vld_q[rd_c_line];
			c_sel_s1 <= line_sel_q[rd_c_line];
		end
	end

	// last next-free write, for the read that shared its edge
	logic          fw_vld_q, fw_con_q;
	logic [LW-1:0] fw_t_q, fw_c_q;
	logic [NW-1:0] fw_val_q;

	logic [5:0]             lines;
	logic [LW-1:0]          t_line, c_line;
	logic                   hit_t, hit_c;
	logic [NW-1:0]          nfs_t, nfs_c, place_full, depth_new;
	logic                   full, ok1, used1;
	gls_pkg::status_t       status1;
	logic [PW-1:0]          place1;
	logic [NW-1:0]          depth_q;
	logic [INDEX_W-1:0]     acc_q;

	assign t_line = LW'(gate_s1.qubit);
	assign c_line = LW'(gate_s1.control);

	always_comb begin
		lines = ({1'b0, qcount_q} < MAXQ) ? {1'b0, qcount_q} : MAXQ;

		hit_t = fw_vld_q && (t_line == fw_t_q || (fw_con_q && t_line == fw_c_q));
		hit_c = fw_vld_q && (c_line == fw_t_q || (fw_con_q && c_line == fw_c_q));
		nfs_t = hit_t ? fw_val_q : (t_vld_s1 ? (t_sel_s1 ? rd_bt : rd_at) : '0);
		nfs_c = hit_c ? fw_val_q : (c_vld_s1 ? (c_sel_s1 ? rd_bc : rd_ac) : '0);

		place_full = nfs_t;
		if (gate_s1.has_control && nfs_c > nfs_t) begin
			place_full = nfs_c;
		end
		full = place_full >= SLICE_LIMIT;

		if ({2'b00, gate_s1.qubit} >= lines) begin
			status1 = gls_pkg::ST_BAD_QUBIT;
		end else if (gate_s1.has_control && {2'b00, gate_s1.control} >= lines) begin
			status1 = gls_pkg::ST_BAD_CONTROL;
		end else if (gate_s1.has_control && gate_s1.control == gate_s1.qubit) begin
			status1 = gls_pkg::ST_SAME_LINE;
		end else if (full) begin
			status1 = gls_pkg::ST_FULL;
		end else begin
			status1 = gls_pkg::ST_OK;
		end
		ok1 = (status1 == gls_pkg::ST_OK);

		place1    = ok1 ? place_full[PW-1:0] : '0;
		nfs_wdata = place_full + NW'(1);
		depth_new = (ok1 && nfs_wdata > depth_q) ? nfs_wdata : depth_q;
		// slices below the depth have all been written at least once
		used1     = place_full < depth_q;
	end

	assign nfs_we_a  = s1_adv && ok1;
	assign nfs_we_b  = s1_adv && ok1 && gate_s1.has_control;
	assign wr_t_line = t_line;
	assign wr_c_line = c_line;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_vld_q <= '0;
			line_sel_q <= '0;
			fw_vld_q   <= 1'b0;
			fw_con_q   <= 1'b0;
			fw_t_q     <= '0;
			fw_c_q     <= '0;
			fw_val_q   <= '0;
			depth_q    <= '0;
			acc_q      <= '0;
		end else if (nfs_we_a) begin
			line_vld_q[t_line] <= 1'b1;
			line_sel_q[t_line] <= 1'b0;
			if (gate_s1.has_control) begin
				line_vld_q[c_line] <= 1'b1;
				line_sel_q[c_line] <= 1'b1;
			end
			fw_vld_q <= 1'b1;
			fw_con_q <= gate_s1.has_control;
			fw_t_q   <= t_line;
			fw_c_q   <= c_line;
			fw_val_q <= nfs_wdata;
			depth_q  <= depth_new;
			if (acc_q != gls_pkg::INDEX_MAX) begin
				acc_q <= acc_q + INDEX_W'(1);
			end
		end
	end

	// ---------------- stage 2: slice gate count ----------------
	gls_pkg::status_t   status_s2;
	logic [PW-1:0]      place_s2;
	logic               used_s2;
	logic [NW-1:0]      depth_s2;
	logic [INDEX_W-1:0] idx_s2;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_s2 <= status1;
			place_s2  <= place1;
			used_s2   <= used1;
			depth_s2  <= depth_new;
			idx_s2    <= ok1 ? acc_q : '0;
		end
	end

	logic [FILL_W-1:0] cnt_rdata, cnt_old, fill_new;
	logic              cnt_we, ok2, cw_hit;
	logic              cw_vld_q;
	logic [PW-1:0]     cw_addr_q;
	logic [FILL_W-1:0] cw_data_q;

	gls_ram #(.WIDTH(FILL_W), .DEPTH(MAX_SLICES)) u_slice_cnt (
		.clk(clk), .we(cnt_we), .waddr(place_s2), .wdata(fill_new),
		.re(s1_adv), .raddr(place1), .rdata(cnt_rdata)
	);

	always_comb begin
		ok2      = (status_s2 == gls_pkg::ST_OK);
		cw_hit   = cw_vld_q && cw_addr_q == place_s2;
		cnt_old  = cw_hit ? cw_data_q : (used_s2 ? cnt_rdata : '0);
		fill_new = (cnt_old < gls_pkg::FILL_MAX) ? cnt_old + FILL_W'(1) : cnt_old;
		cnt_we   = s2_adv && ok2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_vld_q  <= 1'b0;
			cw_addr_q <= '0;
			cw_data_q <= '0;
		end else if (cnt_we) begin
			cw_vld_q  <= 1'b1;
			cw_addr_q <= place_s2;
			cw_data_q <= fill_new;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			result.status     <= status_s2;
			result.slice      <= SLICE_W'(place_s2);
			result.slice_fill <= ok2 ? fill_new : '0;
			result.depth      <= DEPTH_W'(depth_s2);
			result.gate_index <= idx_s2;
		end
	end

	// ---------------- assertions ----------------
	`ASSERT_IMPLIES(a_ok_has_fill, result_valid && result.status == gls_pkg::ST_OK,
		result.slice_fill != '0, "placed gate reports an empty slice")
	`ASSERT_IMPLIES(a_reject_clean, result_valid && result.status != gls_pkg::ST_OK,
		result.slice == '0 && result.slice_fill == '0 && result.gate_index == '0,
		"rejected gate carries placement data")
	`ASSERT_ALWAYS(a_depth_grows, depth_q >= $past(depth_q), "circuit depth decreased")
	`ASSERT_NEXT(a_acc_lands, gate_acc, s1_vld_q, "transferred gate missing from stage 1")

endmodule

FILE: sim/tb_top.sv
// Testbench for the gate layer scheduler: directed and random gates checked against a predictor.
`timescale 1ns / 1ps

// The driver takes gates from a backlog that the stimulus block fills. On every gate
// transfer the predictor places the gate and queues the result it should produce. The
// monitor compares each result transfer with the oldest queued placement.
// Both sides idle at random, with some phases that run without gaps. The line count is
// changed only between phases, once the block has returned every result. A closing phase
// drives two lines up to the slice limit so that the capacity check is reached.
module tb_top;
	import gls_pkg::*;

	localparam int LINES_MAX   = 16;
	localparam int SLICE_COUNT = 1024;

	logic clk;
	logic arst_n = 1'b0;

	logic                cfg_wr_en    = 1'b0;
	logic [QCOUNT_W-1:0] cfg_wr_data  = '0;
	logic                gate_valid   = 1'b0;
	logic                gate_stall;
	gate_t               gate         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;

	// Predictor state: per-line next free slot, per-slice gate count, depth, arrival count.
	logic [DEPTH_W-1:0]  line_free [LINES_MAX]   = '{default: '0};
	logic [FILL_W-1:0]   slice_count [SLICE_COUNT] = '{default: '0};
	logic [DEPTH_W-1:0]  depth_now      = '0;
	logic [INDEX_W-1:0]  gates_taken    = '0;
	logic [QCOUNT_W-1:0] line_count_cfg = QCOUNT_RESET;

	gate_t   gate_backlog [$];
	result_t pending_placements [$];

	int unsigned gap_left   = 0;
	int unsigned stall_left = 0;
	int unsigned fault_count = 0;
	bit          feed_idle_on  = 1'b1;
	bit          drain_idle_on = 1'b1;

	gate_layer_scheduler_top #(
		.MAX_QUBITS (LINES_MAX),
		.MAX_SLICES (SLICE_COUNT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.gate_valid   (gate_valid),
		.gate_stall   (gate_stall),
		.gate         (gate),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Usable lines: a count above the line limit is clipped to it.
	function automatic int unsigned usable_lines();
		return (line_count_cfg < LINES_MAX) ? line_count_cfg : LINES_MAX;
	endfunction

	// ASAP placement of one gate. Checks run in order qubit, control range, same line,
	// capacity; the first failure gives the status and leaves all state untouched.
	function automatic result_t schedule_gate(gate_t g);
		result_t         r;
		int unsigned     lines;
		logic [DEPTH_W-1:0] place;
		r = '0;
		lines = usable_lines();
		if (g.qubit >= lines) begin
			r.status = ST_BAD_QUBIT;
		end else if (g.has_control && g.control >= lines) begin
			r.status = ST_BAD_CONTROL;
		end else if (g.has_control && g.control == g.qubit) begin
			r.status = ST_SAME_LINE;
		end else begin
			place = line_free[g.qubit];
			if (g.has_control && line_free[g.control] > place)
				place = line_free[g.control];
			if (place >= SLICE_COUNT) begin
				r.status = ST_FULL;
			end else begin
				line_free[g.qubit] = place + 1'b1;
				if (g.has_control)
					line_free[g.control] = place + 1'b1;
				if (place + 1'b1 > depth_now)
					depth_now = place + 1'b1;
				if (slice_count[place] < FILL_MAX)
					slice_count[place] = slice_count[place] + 1'b1;
				r.status     = ST_OK;
				r.slice      = place[SLICE_W-1:0];
				r.slice_fill = slice_count[place];
				r.gate_index = gates_taken;
				if (gates_taken != INDEX_MAX)
					gates_taken = gates_taken + 1'b1;
			end
		end
		r.depth = depth_now;
		return r;
	endfunction

	// Idle length: mostly none, often short, now and then long.
	function automatic int unsigned pick_gap(bit enabled);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: valid stays up, payload held, until the transfer; then an optional gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (gate_valid && !gate_stall)
				pending_placements.push_back(schedule_gate(gate));
			if ((gate_valid && !gate_stall) || !gate_valid) begin
				if (gap_left != 0) begin
					gap_left   <= gap_left - 1;
					gate_valid <= 1'b0;
				end else if (gate_backlog.size() != 0) begin
					gate       <= gate_backlog.pop_front();
					gate_valid <= 1'b1;
					gap_left   <= pick_gap(feed_idle_on);
				end else begin
					gate_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer, then pick the stall for the next cycle.
	always @(posedge clk) begin
		result_t want;
		int unsigned n;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_placements.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("[%0t] result with no gate pending: status %0d slice %0d",
							$realtime, result.status, result.slice);
				end else begin
					want = pending_placements.pop_front();
					if (result.status !== want.status || result.slice !== want.slice ||
						result.slice_fill !== want.slice_fill ||
						result.depth !== want.depth ||
						result.gate_index !== want.gate_index) begin
						fault_count++;
						if (fault_count <= 10) begin
							$write("[%0t] mismatch: exp st %0d sl %0d fill %0d dep %0d idx %0d,",
								$realtime, want.status, want.slice, want.slice_fill,
								want.depth, want.gate_index);
							$display(" got st %0d sl %0d fill %0d dep %0d idx %0d",
								result.status, result.slice, result.slice_fill,
								result.depth, result.gate_index);
						end
					end
				end
			end
			if (stall_left != 0) begin
				stall_left   <= stall_left - 1;
				result_stall <= 1'b1;
			end else begin
				n = pick_gap(drain_idle_on);
				result_stall <= (n != 0);
				stall_left   <= (n != 0) ? n - 1 : 0;
			end
		end
	end

	// Block is idle once no gate waits, none is offered and every result has come back.
	task automatic drain();
		while (gate_backlog.size() != 0 || gate_valid || pending_placements.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_line_count(logic [QCOUNT_W-1:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en      <= 1'b0;
		line_count_cfg = value;
	endtask

	function automatic void push_gate(logic [QUBIT_W-1:0] q, logic hc, logic [QUBIT_W-1:0] c);
		gate_t g;
		g.qubit       = q;
		g.has_control = hc;
		g.control     = c;
		gate_backlog.push_back(g);
	endfunction

	// Tidy gates are legal for the current count when it is not zero; the rest is raw noise on every bit.
	function automatic gate_t random_gate(bit tidy);
		gate_t       g;
		int unsigned lines;
		lines         = usable_lines();
		g.qubit       = QUBIT_W'($urandom_range(0, 15));
		g.has_control = 1'($urandom_range(0, 1));
		g.control     = QUBIT_W'($urandom_range(0, 15));
		if (tidy && lines != 0) begin
			g.qubit = QUBIT_W'($urandom_range(0, lines - 1));
			if (lines < 2) begin
				g.has_control = 1'b0;
			end else if (g.has_control) begin
				g.control = QUBIT_W'($urandom_range(0, lines - 2));
				if (g.control >= g.qubit)
					g.control = g.control + 1'b1;
			end
		end
		return g;
	endfunction

	task automatic random_phase(logic [QCOUNT_W-1:0] count, int unsigned items);
		set_line_count(count);
		feed_idle_on  = ($urandom_range(0, 3) != 0);
		drain_idle_on = ($urandom_range(0, 3) != 0);
		repeat (items)
			gate_backlog.push_back(random_gate($urandom_range(0, 99) < 85));
	endtask

	initial begin
		int unsigned fill_needed;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset count of 16: one gate per line lands in slice 0 and fills it to 16.
		for (int i = 0; i < LINES_MAX; i++)
			push_gate(QUBIT_W'(i), 1'b0, 4'd0);
		push_gate(4'd15, 1'b1, 4'd0);   // two-line gate on the top and bottom lines
		push_gate(4'd3, 1'b1, 4'd3);    // control on its own target
		push_gate(4'd0, 1'b0, 4'd0);    // control field ignored without has_control
		push_gate(4'd5, 1'b0, 4'd5);

		// Single line: only line 0 exists.
		set_line_count(5'd1);
		push_gate(4'd0, 1'b0, 4'd9);
		push_gate(4'd1, 1'b0, 4'd0);
		push_gate(4'd0, 1'b1, 4'd1);
		push_gate(4'd0, 1'b1, 4'd0);

		// Eight lines: qubit check wins over the same-line check, control range next.
		set_line_count(5'd8);
		push_gate(4'd9, 1'b1, 4'd9);
		push_gate(4'd2, 1'b1, 4'd9);
		push_gate(4'd7, 1'b1, 4'd6);

		// Zero lines rejects everything on the qubit check.
		set_line_count(5'd0);
		push_gate(4'd0, 1'b0, 4'd0);
		push_gate(4'd0, 1'b1, 4'd15);

		// Count past the line limit is clipped to 16.
		set_line_count(5'd31);
		push_gate(4'd15, 1'b1, 4'd14);
		push_gate(4'd14, 1'b1, 4'd15);

		random_phase(5'd16, 50);
		random_phase(5'd31, 50);
		random_phase(QCOUNT_W'($urandom_range(1, 31)), 50);
		random_phase(5'd2, 50);
		random_phase(5'd17, 50);
		random_phase(QCOUNT_W'($urandom_range(0, 31)), 50);
		random_phase(5'd1, 50);
		random_phase(QCOUNT_W'($urandom_range(3, 16)), 50);

		// Capacity: push lines 0 and 1 to the last slice and beyond it.
		set_line_count(5'd16);
		feed_idle_on  = 1'b1;
		drain_idle_on = 1'b1;
		fill_needed = SLICE_COUNT -
			((line_free[0] > line_free[1]) ? line_free[0] : line_free[1]);
		repeat (fill_needed + 3)
			push_gate(4'd0, 1'b1, 4'd1);
		push_gate(4'd1, 1'b0, 4'd0);
		push_gate(4'd2, 1'b1, 4'd0);
		random_phase(5'd16, 40);

		drain();
		repeat (8) @(posedge clk);
		if (fault_count == 0 && pending_placements.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog, well past the slowest legal run.
	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
